// ----- design/dq_pkg.sv -----
package dq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_IW    = 1;
  localparam int CQ_CW    = 2;

  // result buffer
  localparam int OB_DEPTH = 4;
  localparam int OB_IW    = 2;
  localparam int OB_CW    = 3;

  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  // ring slot of (head + off), off < DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [IDX_W:0] s;
    s = (IDX_W + 1)'(head) + (IDX_W + 1)'(off);
    if (s >= (IDX_W + 1)'(DEPTH)) s = s - (IDX_W + 1)'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- design/dq_front.sv -----
module dq_front import dq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t             q [CQ_DEPTH];
  logic [CQ_IW-1:0] wp;
  logic [CQ_IW-1:0] rp;
  logic [CQ_CW-1:0] cnt;
  logic             accept;
  logic             enq;

  assign full      = (cnt == CQ_CW'(CQ_DEPTH));
  assign accept    = push && !full;
  // unused codes are taken and dropped here
  assign enq       = accept && (in_item.func <= FN_DUMP);
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp].func  <= in_item.func;
      q[wp].value <= in_item.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (enq) wp <= wp + CQ_IW'(1);
      if (cmd_take) rp <= rp + CQ_IW'(1);
      unique case ({enq, cmd_take})
        2'b10:   cnt <= cnt + CQ_CW'(1);
        2'b01:   cnt <= cnt - CQ_CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- design/dq_back.sv -----
module dq_back import dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] dump_i, dump_i_next;

  logic [31:0]      entry_store [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [31:0]      mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  logic [31:0]      rd_data;

  out_item_t        ob [OB_DEPTH];
  logic [OB_IW-1:0] ob_wp, ob_rp;
  logic [OB_CW-1:0] ob_cnt;
  logic             ob_we;
  out_item_t        ob_wd;
  logic             ob_rd;
  logic             room;
  logic [IDX_W-1:0] head_dec;
  logic [CNT_W-1:0] dump_n;

  assign room     = (ob_cnt != OB_CW'(OB_DEPTH));
  assign empty    = (ob_cnt == '0);
  assign ob_rd    = pop && !empty;
  assign out_item = ob[ob_rp];
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign dump_n   = dump_i + CNT_W'(1);

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    dump_i_next = dump_i;
    cmd_take    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = head;
    mem_wd      = cmd.value;
    mem_re      = 1'b0;
    mem_ra      = head;
    ob_we       = 1'b0;
    ob_wd       = '{out_value: '0, status: ST_OK, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && room) begin
          cmd_take = 1'b1;
          unique case (cmd.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              ob_we = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                ob_wd.status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (cmd.func == FN_PUSH_FRONT) begin
                  mem_wa    = head_dec;
                  head_next = head_dec;
                end else begin
                  mem_wa = slot_of(head, count);
                end
                count_next      = count + CNT_W'(1);
                ob_wd.out_value = cmd.value;
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              if (count == '0) begin
                ob_we        = 1'b1;
                ob_wd.status = ST_EMPTY;
              end else begin
                mem_re = 1'b1;
                if (cmd.func == FN_POP_FRONT) begin
                  mem_ra    = head;
                  head_next = slot_of(head, CNT_W'(1));
                end else begin
                  mem_ra = slot_of(head, count - CNT_W'(1));
                end
                count_next = count - CNT_W'(1);
                state_next = S_POP;
              end
            end
            FN_DUMP: begin
              if (count == '0) begin
                ob_we        = 1'b1;
                ob_wd.status = ST_EMPTY;
              end else begin
                mem_re      = 1'b1;
                mem_ra      = head;
                dump_i_next = '0;
                state_next  = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (room) begin
          ob_we           = 1'b1;
          ob_wd.out_value = $signed(rd_data);
          state_next      = S_IDLE;
        end
      end
      S_DUMP: begin
        // one entry per cycle while the result buffer has room; next read goes out as this one lands
        if (room) begin
          ob_we           = 1'b1;
          ob_wd.out_value = $signed(rd_data);
          ob_wd.last      = (dump_n == count);
          if (dump_n == count) begin
            state_next = S_IDLE;
          end else begin
            mem_re      = 1'b1;
            mem_ra      = slot_of(head, dump_n);
            dump_i_next = dump_n;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) entry_store[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= entry_store[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (ob_we) ob[ob_wp] <= ob_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      dump_i <= '0;
      ob_wp  <= '0;
      ob_rp  <= '0;
      ob_cnt <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      dump_i <= dump_i_next;
      if (ob_we) ob_wp <= ob_wp + OB_IW'(1);
      if (ob_rd) ob_rp <= ob_rp + OB_IW'(1);
      unique case ({ob_we, ob_rd})
        2'b10:   ob_cnt <= ob_cnt + OB_CW'(1);
        2'b01:   ob_cnt <= ob_cnt - OB_CW'(1);
        default: ob_cnt <= ob_cnt;
      endcase
    end
  end

endmodule

// ----- design/double_ended_queue_top.sv -----
// Result path: a push or an error result is written to the result buffer as its command is taken;
//   a pop result and each dump result first pass through the registered memory read.
// Sequencing: the single back-end sequencer handles one command at a time; a pop or a dump
//   keeps new commands waiting until its results are written, and every result waits for room.
// Reset: synchronous rst empties the deque and both internal queues; store contents are
//   left as they are and are never read before being written.
module double_ended_queue_top import dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  dq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ----- design/dq_checker.sv -----
module dq_checker import dq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before transfer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.status == ST_OK || out_item.status == ST_EMPTY ||
                out_item.status == ST_FULL))
    else $error("bad status code");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status != ST_OK) |-> (out_item.last && out_item.out_value == 0))
    else $error("error result not final or not zero");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
